>>> hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared widths, wedge entry and control types for the sliding min/max filter.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned POS_BITS    = 11;
  localparam int unsigned WIN_BITS    = 11;
  localparam int unsigned FILL_BITS   = 11;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [WIN_BITS-1:0]           win_t;
  typedef logic [FILL_BITS-1:0]          fill_t;

  localparam win_t  WIN_MIN  = win_t'(1);
  localparam win_t  WIN_MAX  = win_t'(MAX_WINDOW);
  localparam fill_t FILL_MAX = '1;

  // one wedge slot: candidate value and the position it arrived at
  typedef struct packed {
    logic    valid;
    sample_t val;
    pos_t    pos;
  } entry_t;

  // per-cell control, common to every cell of a chain
  typedef struct packed {
    logic accept;
    logic start;
    logic pop;
  } cell_ctrl_t;

  // top level to wedge
  typedef struct packed {
    logic accept;
    logic start;
    logic pop_req;
  } wedge_ctrl_t;

  // wedge to top level: head expiry status
  typedef struct packed {
    logic pop_two;
  } wedge_stat_t;

  function automatic win_t clamp_window(input win_t w);
    win_t r;
    if (w == '0) begin
      r = WIN_MIN;
    end else if (w > WIN_MAX) begin
      r = WIN_MAX;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/swmm_if.sv
// ----------------------------------------------------------------------------
// swmm_if
// Valid/ready channels of the sliding min/max filter: samples, results, window.
// ----------------------------------------------------------------------------
interface swmm_in_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_req;
  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface swmm_out_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t min_value;
  sample_t max_value;
  modport source (output valid, output min_value, output max_value, input ready);
  modport sink (input valid, input min_value, input max_value, output ready);
endinterface

interface swmm_cfg_if;
  import swmm_pkg::*;
  logic valid;
  logic ready;
  win_t window_length;
  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

>>> hw/rtl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Running minimum and maximum over the last window_length samples, kept in two
// monotonic wedges built as cell chains. The lower wedge runs on inverted
// samples so both chains use the same cell.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | word accepted when
//  in_if   | in  | sample, start_req            | in_if.valid & in_if.ready
//  out_if  | out | min_value, max_value          | out_if.valid & out_if.ready
//  cfg_if  | in  | window_length                | cfg_if.valid & cfg_if.ready
//
// One input word per cycle in steady state; a result shows in the cycle after
// its input word is accepted, from the output register.
// After the window shrinks, the next word waits while the surplus expired head
// entries drain: each wedge retires one head per cycle.
// Reset clears the cell valid bits at once; no clearing pass.
// Otherwise input stalls only while the output register holds an untaken word.
// ----------------------------------------------------------------------------
module sliding_window_min_max (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmm_in_if.sink    in_if,
  swmm_out_if.source out_if,
  swmm_cfg_if.sink   cfg_if
);
  import swmm_pkg::*;

  win_t        win_q;
  win_t        win_eff;
  pos_t        pos_q;
  fill_t       fill_q;
  fill_t       fill_d;
  logic        out_valid_q;
  sample_t     min_q;
  sample_t     max_q;
  wedge_ctrl_t wctrl;
  wedge_stat_t stat_up;
  wedge_stat_t stat_lo;
  sample_t     head_up;
  sample_t     head_lo;
  sample_t     x_inv;
  logic        multi_pop;
  logic        out_space;
  logic        accept;
  logic        produce;

  assign win_eff   = clamp_window(win_q);
  assign multi_pop = stat_up.pop_two || stat_lo.pop_two;
  assign out_space = !out_valid_q || out_if.ready;

  assign in_if.ready  = !multi_pop && out_space;
  assign accept       = in_if.valid && in_if.ready;
  // hold off window writes while a waiting word drains expired heads
  assign cfg_if.ready = !(in_if.valid && multi_pop);

  assign wctrl.accept  = accept;
  assign wctrl.start   = in_if.start_req;
  assign wctrl.pop_req = accept || (in_if.valid && multi_pop);

  assign x_inv = ~in_if.sample;

  swmm_wedge u_upper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (wctrl),
    .x_i      (in_if.sample),
    .pos_i    (pos_q),
    .win_i    (win_eff),
    .stat_o   (stat_up),
    .head_d_o (head_up)
  );

  swmm_wedge u_lower (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (wctrl),
    .x_i      (x_inv),
    .pos_i    (pos_q),
    .win_i    (win_eff),
    .stat_o   (stat_lo),
    .head_d_o (head_lo)
  );

  always_comb begin
    if (in_if.start_req) begin
      fill_d = fill_t'(1);
    end else if (fill_q == FILL_MAX) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + fill_t'(1);
    end
  end

  assign produce = (win_t'(fill_d) >= win_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_MIN;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        win_q <= cfg_if.window_length;
      end
      if (accept) begin
        pos_q  <= pos_q + pos_t'(1);
        fill_q <= fill_d;
      end
      if (accept && produce) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      max_q <= head_up;
      min_q <= ~head_lo;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.min_value = min_q;
  assign out_if.max_value = max_q;

endmodule

>>> hw/rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One wedge slot. Shifts toward the head on a pop, drops itself when the new
// sample dominates it, and takes the new sample when it is the first free slot.
// ----------------------------------------------------------------------------
module swmm_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swmm_pkg::cell_ctrl_t   ctrl_i,
  input  swmm_pkg::sample_t      x_i,
  input  swmm_pkg::pos_t         pos_i,
  input  swmm_pkg::entry_t       right_i,
  input  logic                   left_keep_i,
  output swmm_pkg::entry_t       entry_o,
  output logic                   keep_o
);
  import swmm_pkg::*;

  logic    valid_q;
  sample_t val_q;
  pos_t    pos_q;
  entry_t  cur;
  entry_t  shifted;
  entry_t  entry_d;
  logic    keep;

  always_comb begin
    cur     = '{valid: valid_q, val: val_q, pos: pos_q};
    shifted = ctrl_i.pop ? right_i : cur;
    // survives if strictly above the new sample (equal ones are replaced)
    keep    = shifted.valid && !ctrl_i.start && ($signed(shifted.val) > $signed(x_i));
    entry_d = shifted;
    if (ctrl_i.accept && !keep) begin
      entry_d.valid = left_keep_i;
      entry_d.val   = x_i;
      entry_d.pos   = pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= entry_d.val;
    pos_q <= entry_d.pos;
  end

  assign entry_o = cur;
  assign keep_o  = keep;

endmodule

>>> hw/rtl/swmm_wedge.sv
// ----------------------------------------------------------------------------
// swmm_wedge
// Monotonic wedge as a chain of cells with the head fixed at cell 0. Values
// strictly decrease from head to tail; the head is the running maximum.
// ----------------------------------------------------------------------------
module swmm_wedge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swmm_pkg::wedge_ctrl_t ctrl_i,
  input  swmm_pkg::sample_t     x_i,
  input  swmm_pkg::pos_t        pos_i,
  input  swmm_pkg::win_t        win_i,
  output swmm_pkg::wedge_stat_t stat_o,
  output swmm_pkg::sample_t     head_d_o
);
  import swmm_pkg::*;

  entry_t     ent  [MAX_WINDOW+1];
  logic       kp   [MAX_WINDOW];
  cell_ctrl_t cctrl;
  pos_t       age0;
  pos_t       age1;
  logic       exp0;
  logic       exp1;
  entry_t     head_shift;

  // slot past the tail never holds anything
  assign ent[MAX_WINDOW] = '0;

  // age against the incoming sample's position; wraps cleanly in 11 bits
  assign age0 = pos_i - ent[0].pos;
  assign age1 = pos_i - ent[1].pos;
  assign exp0 = ent[0].valid && (win_t'(age0) >= win_i);
  assign exp1 = ent[1].valid && (win_t'(age1) >= win_i);

  assign stat_o.pop_two = exp0 && exp1;

  assign cctrl.accept = ctrl_i.accept;
  assign cctrl.start  = ctrl_i.start;
  assign cctrl.pop    = ctrl_i.pop_req && exp0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic left_keep;
    if (k == 0) begin : g_head
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_keep = kp[k-1];
    end
    swmm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctrl),
      .x_i         (x_i),
      .pos_i       (pos_i),
      .right_i     (ent[k+1]),
      .left_keep_i (left_keep),
      .entry_o     (ent[k]),
      .keep_o      (kp[k])
    );
  end

  // head value after this word's update
  assign head_shift = cctrl.pop ? ent[1] : ent[0];
  assign head_d_o   = kp[0] ? head_shift.val : x_i;

endmodule

>>> hw/rtl/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks for the sliding min/max filter, bound to the top level.
// ----------------------------------------------------------------------------
module swmm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              cfg_ready_i,
  input swmm_pkg::sample_t min_value_i,
  input swmm_pkg::sample_t max_value_i
);
  import swmm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(min_value_i)
                                       && $stable(max_value_i)))
    else $error("result word changed while stalled");

  // a fresh result only follows an accepted input word
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without input word");

  // both extremes come from sets holding the newest sample
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($signed(min_value_i) <= $signed(max_value_i)))
    else $error("min above max");

  // window writes are only held off while input is held off too
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_i |-> (in_valid_i && !in_ready_i))
    else $error("window port blocked without a draining input word");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .cfg_ready_i (cfg_if.ready),
  .min_value_i (out_if.min_value),
  .max_value_i (out_if.max_value)
);

>>> sim/minmax_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minmax_checker
// Watches the sample, window and result channels of the sliding min/max
// filter. Keeps its own pair of wedges, predicts each result word and
// compares it with the next word that the block hands out.
// ----------------------------------------------------------------------------
module minmax_checker (
  input  logic clk_i,
  input  logic rst_ni,
  swmm_in_if   in_if,
  swmm_out_if  out_if,
  swmm_cfg_if  cfg_if,
  output int   fail_count_o,
  output int   pending_o,
  output int   result_count_o
);
  import swmm_pkg::*;

  localparam int DEPTH          = MAX_WINDOW + 1;
  localparam int FILL_LIMIT     = 2047;
  localparam int MISMATCH_SHOWN = 10;

  typedef enum int {SIDE_MAX = 0, SIDE_MIN = 1} side_e;

  typedef struct packed {
    sample_t min_value;
    sample_t max_value;
  } minmax_t;

  // candidate extremes per side, kept as rings
  sample_t cand_val [2][DEPTH];
  pos_t    cand_pos [2][DEPTH];
  int      head_idx [2];
  int      tail_idx [2];
  int      cand_cnt [2];
  pos_t    next_pos;
  int      fill_cnt;
  win_t    window_reg;
  minmax_t minmax_q [$];

  function automatic void note_failure(input string text);
    fail_count_o++;
    if (fail_count_o <= MISMATCH_SHOWN) begin
      $display("%0t: %s", $time, text);
    end
  endfunction

  function automatic void empty_wedges();
    for (int s = 0; s < 2; s++) begin
      head_idx[s] = 0;
      tail_idx[s] = 0;
      cand_cnt[s] = 0;
    end
  endfunction

  // drop tail entries that the new sample dominates (ties go to the newer one)
  function automatic void push_candidate(input side_e s, input sample_t x, input pos_t p);
    int   last;
    logic drop;
    while (cand_cnt[s] > 0) begin
      last = (tail_idx[s] + DEPTH - 1) % DEPTH;
      drop = (s == SIDE_MAX) ? (cand_val[s][last] <= x) : (cand_val[s][last] >= x);
      if (!drop) break;
      tail_idx[s] = last;
      cand_cnt[s]--;
    end
    cand_val[s][tail_idx[s]] = x;
    cand_pos[s][tail_idx[s]] = p;
    tail_idx[s] = (tail_idx[s] + 1) % DEPTH;
    cand_cnt[s]++;
  endfunction

  function automatic void retire_old(input side_e s, input pos_t p, input int span);
    pos_t age;
    while (cand_cnt[s] > 0) begin
      age = p - cand_pos[s][head_idx[s]];
      if (int'(age) < span) break;
      head_idx[s] = (head_idx[s] + 1) % DEPTH;
      cand_cnt[s]--;
    end
  endfunction

  function automatic void add_sample(input sample_t x, input logic first);
    int      span;
    minmax_t res;
    if (window_reg == '0) begin
      span = 1;
    end else if (window_reg > MAX_WINDOW) begin
      span = MAX_WINDOW;
    end else begin
      span = int'(window_reg);
    end
    if (first) begin
      empty_wedges();
      fill_cnt = 0;
    end
    push_candidate(SIDE_MAX, x, next_pos);
    push_candidate(SIDE_MIN, x, next_pos);
    retire_old(SIDE_MAX, next_pos, span);
    retire_old(SIDE_MIN, next_pos, span);
    next_pos = next_pos + 1'b1;
    if (fill_cnt < FILL_LIMIT) fill_cnt++;
    if (fill_cnt >= span) begin
      res.min_value = cand_val[SIDE_MIN][head_idx[SIDE_MIN]];
      res.max_value = cand_val[SIDE_MAX][head_idx[SIDE_MAX]];
      minmax_q.push_back(res);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    minmax_t want;
    minmax_t got;
    if (!rst_ni) begin
      empty_wedges();
      next_pos       = '0;
      fill_cnt       = 0;
      window_reg     = WIN_MIN;
      minmax_q.delete();
      fail_count_o   = 0;
      result_count_o = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) window_reg = cfg_if.window_length;
      // a result word always belongs to an earlier sample, so check it first
      if (out_if.valid && out_if.ready) begin
        got.min_value = out_if.min_value;
        got.max_value = out_if.max_value;
        result_count_o++;
        if (minmax_q.size() == 0) begin
          note_failure($sformatf("unexpected result word: min %0d max %0d",
                                 got.min_value, got.max_value));
        end else begin
          want = minmax_q.pop_front();
          if (got.min_value !== want.min_value || got.max_value !== want.max_value) begin
            note_failure($sformatf("mismatch: expected min %0d max %0d, got min %0d max %0d",
                                   want.min_value, want.max_value,
                                   got.min_value, got.max_value));
          end
        end
      end
      if (in_if.valid && in_if.ready) add_sample(in_if.sample, in_if.start_req);
    end
    pending_o = minmax_q.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and window writes into the sliding min/max filter with
// random gaps and result back-pressure; the checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import swmm_pkg::*;

  localparam int      RANDOM_SAMPLES = 525;
  localparam int      RAMP_LEN       = 80;
  localparam int      RAMP_STEP      = 63;
  localparam int      SETTLE_CYCLES  = 8;
  localparam int      TAIL_CYCLES    = 20;
  localparam sample_t SAMPLE_LO      = 16'sh8000;
  localparam sample_t SAMPLE_HI      = 16'sh7FFF;
  localparam win_t    WIN_ALL_ONES   = '1;

  typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_RISING, PAT_FALLING, PAT_EXTREME} pattern_e;

  logic clk_i;
  logic rst_ni;
  bit   send_burst;
  bit   take_burst;
  int   fail_count;
  int   pending;
  int   result_count;
  int   sample_count;
  int   window_writes;
  win_t cur_window;

  swmm_in_if  in_if ();
  swmm_out_if out_if ();
  swmm_cfg_if cfg_if ();

  sliding_window_min_max i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  minmax_checker i_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .out_if         (out_if),
    .cfg_if         (cfg_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout: run did not drain");
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, ready held high through burst stretches
  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = take_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input sample_t s, input logic first);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample    <= s;
    in_if.start_req <= first;
    do @(posedge clk_i); while (!in_if.ready);
    sample_count++;
    @(negedge clk_i);
  endtask

  // hold off the sender until every predicted word has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_window(input win_t w);
    settle();
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    cur_window = w;
    window_writes++;
  endtask

  function automatic sample_t draw_sample(input pattern_e pat, input sample_t prev);
    sample_t s;
    case (pat)
      PAT_NARROW:  s = sample_t'($urandom_range(0, 6)) - sample_t'(3);
      PAT_RISING:  s = prev + sample_t'($urandom_range(0, 3));
      PAT_FALLING: s = prev - sample_t'($urandom_range(0, 3));
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       s = SAMPLE_LO;
          1:       s = SAMPLE_HI;
          2:       s = '0;
          default: s = '1;
        endcase
      end
      default:     s = sample_t'($urandom());
    endcase
    return s;
  endfunction

  initial begin
    int       r;
    int       span;
    int       vectors;
    int       len;
    int       random_done;
    win_t     w;
    pattern_e pat;
    sample_t  s;
    logic     first;

    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.start_req      = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.window_length = '0;
    send_burst           = 1'b0;
    take_burst           = 1'b0;
    cur_window           = WIN_MIN;
    sample_count         = 0;
    window_writes        = 0;
    rst_ni               = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // window 1 out of reset; first words carry no start flag
    send_sample(SAMPLE_HI, 1'b0);
    send_sample(SAMPLE_LO, 1'b0);
    send_sample('0, 1'b1);
    send_sample('1, 1'b0);
    set_window('0);                 // zero acts as one
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
    set_window(win_t'(3));
    send_sample(16'sd5, 1'b1);      // equal run: newer copy wins
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(SAMPLE_LO, 1'b0);
    send_sample(SAMPLE_HI, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);          // restart mid-stream
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b0);
    set_window(win_t'(2));          // shrink without restart
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b0);
    set_window(win_t'(12));         // grow: output pauses until refilled
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);

    random_done = 0;
    while (random_done < RANDOM_SAMPLES) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        w = '0;
      end else if (r < 55) begin
        w = win_t'($urandom_range(1, 6));
      end else if (r < 88) begin
        w = win_t'($urandom_range(7, 24));
      end else begin
        w = win_t'($urandom_range(25, 64));
      end
      if ($urandom_range(0, 3) != 0) begin
        set_window(w);
      end else begin
        settle();
      end
      send_burst = ($urandom_range(0, 3) == 0);
      take_burst = ($urandom_range(0, 3) == 0);
      if (cur_window == '0) begin
        span = 1;
      end else if (cur_window > MAX_WINDOW) begin
        span = MAX_WINDOW;
      end else begin
        span = int'(cur_window);
      end
      vectors = $urandom_range(1, 4);
      for (int v = 0; v < vectors && random_done < RANDOM_SAMPLES; v++) begin
        pat = pattern_e'($urandom_range(0, 4));
        len = span + $urandom_range(0, 2 * span + 6);
        if (len > RANDOM_SAMPLES - random_done) len = RANDOM_SAMPLES - random_done;
        s   = sample_t'($urandom());
        for (int i = 0; i < len; i++) begin
          s = draw_sample(pat, s);
          // the first vector sometimes carries on across a window change
          if (i == 0) begin
            first = (v != 0) || ($urandom_range(0, 4) != 0);
          end else begin
            first = ($urandom_range(0, 49) == 0);
          end
          send_sample(s, first);
          random_done++;
        end
        if ($urandom_range(0, 9) == 0) settle();
      end
    end

    // deep wedges under an oversized window, then a large shrink that makes
    // the block retire many heads in a row
    send_burst = 1'b0;
    take_burst = 1'b0;
    set_window(WIN_ALL_ONES);
    for (int i = 0; i < RAMP_LEN; i++) begin
      send_sample(SAMPLE_HI - sample_t'(i * RAMP_STEP), i == 0);
    end
    set_window(win_t'(3));
    for (int i = 0; i < 20; i++) begin
      send_sample(sample_t'($urandom()), 1'b0);
    end
    set_window(win_t'(MAX_WINDOW + 1));
    for (int i = 0; i < RAMP_LEN; i++) begin
      send_sample(SAMPLE_LO + sample_t'(i * RAMP_STEP), i == 0);
    end
    set_window(win_t'(5));
    for (int i = 0; i < 20; i++) begin
      send_sample(sample_t'($urandom()), 1'b0);
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Covered %0d samples, %0d min/max results, %0d window writes",
             sample_count, result_count, window_writes);
    $display("Windows 0 to 2047, restarts, equal runs, deep ramps and big shrinks included");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_if.sv
hw/rtl/swmm_cell.sv
hw/rtl/swmm_wedge.sv
hw/rtl/sliding_window_min_max.sv
hw/rtl/swmm_checker.sv
sim/minmax_checker.sv
sim/tb_top.sv
